@@ hw/rtl/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// mexp_pkg: modular exponentiation shared types and constants
// Field widths, the prime modulus and the Barrett constants used by the
// shared modular multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int BaseW  = 64;
    localparam int ExpW   = 63;
    localparam int PowerW = 30;

    // residue width: the prime is below 2^30
    localparam int ResW = 30;

    typedef logic [ResW-1:0] mexp_res_t;

    localparam mexp_res_t   Modulus   = 30'd1000000007;
    // 2^30 mod p, used to fold 30-bit digits together
    localparam mexp_res_t   FoldConst = 30'd73741817;
    localparam logic [31:0] ModTwice  = 32'd2000000014;

    // Barrett factor floor(2^60 / p), below 2^31
    localparam logic [63:0] BarrettMuWide = (64'd1 << 60) / 64'd1000000007;
    localparam logic [30:0] BarrettMu     = BarrettMuWide[30:0];

    // request to the shared modular multiplier: result = (a * b + c) mod p
    typedef struct packed {
        logic      start;
        mexp_res_t a;
        mexp_res_t b;
        mexp_res_t c;
    } mexp_mm_req_t;

endpackage

@@ hw/rtl/mexp_if.sv @@
// ----------------------------------------------------------------------------
// mexp_if: request and response channels
// Valid/ready channels; one transfer happens when valid and ready are high
// at a rising clock edge.
// ----------------------------------------------------------------------------
interface mexp_in_if
    import mexp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [BaseW-1:0] base;
    logic        [ExpW-1:0]  exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if
    import mexp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PowerW-1:0] power;

    modport source (output valid, output power, input ready);
    modport sink   (input valid, input power, output ready);
endinterface

@@ hw/rtl/modular_exponentiation_top.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_top: base^exponent mod 1000000007
// Reduces a signed 64-bit base modulo the prime, then runs right-to-left
// square-and-multiply over the exponent on one shared modular multiplier.
// ----------------------------------------------------------------------------
// One item is worked at a time; the request side is ready only while the
// sequencer is idle. Every modular product runs on the shared Barrett
// multiplier, one after another: 2 products reduce the base, then one
// square per exponent bit below the top one and one multiply per set bit.
// A zero exponent needs only the base reduction. The result sits in an
// output register, so the next request is taken while it waits.
module modular_exponentiation_top
    import mexp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    mexp_in_if.sink           req,
    mexp_out_if.source        rsp
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_RED_HI = 7'b0000010,
        ST_RED_LO = 7'b0000100,
        ST_SIGN   = 7'b0001000,
        ST_MULT   = 7'b0010000,
        ST_SQUARE = 7'b0100000,
        ST_FIN    = 7'b1000000
    } mexp_state_t;

    mexp_state_t  state_reg, state_next;
    logic         issued_reg, issued_next;
    logic         out_valid_reg, out_valid_next;
    logic [63:0]  mag_reg;
    logic         neg_reg;
    logic [ExpW-1:0] exp_reg;
    mexp_res_t    r_reg, acc_reg, sq_reg, power_reg;

    logic [63:0]  base_bits, mag;
    logic [ExpW-1:0] exp_shift;
    logic         in_xfer, out_load, op_state;
    mexp_mm_req_t mm_req;
    logic         mm_done;
    mexp_res_t    mm_result;
    mexp_res_t    sign_res;

    mexp_modmul u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mm_req),
        .done   (mm_done),
        .result (mm_result)
    );

    assign base_bits = req.base;
    assign mag       = base_bits[63] ? (~base_bits + 64'd1) : base_bits;
    assign exp_shift = {1'b0, exp_reg[ExpW-1:1]};

    assign req.ready = (state_reg == ST_IDLE);
    assign in_xfer   = req.valid && req.ready;
    assign out_load  = (state_reg == ST_FIN) && (!out_valid_reg || rsp.ready);

    assign op_state  = (state_reg == ST_RED_HI) || (state_reg == ST_RED_LO) ||
                       (state_reg == ST_MULT)   || (state_reg == ST_SQUARE);

    assign sign_res  = (neg_reg && r_reg != '0) ? (Modulus - r_reg) : r_reg;

    // operand selection for the shared multiplier
    always_comb
    begin
        mm_req.start = op_state && !issued_reg;
        mm_req.a     = '0;
        mm_req.b     = '0;
        mm_req.c     = '0;
        unique case (state_reg)
            ST_RED_HI:
            begin
                mm_req.a = {26'd0, mag_reg[63:60]};
                mm_req.b = FoldConst;
                mm_req.c = mag_reg[59:30];
            end
            ST_RED_LO:
            begin
                mm_req.a = r_reg;
                mm_req.b = FoldConst;
                mm_req.c = mag_reg[29:0];
            end
            ST_MULT:
            begin
                mm_req.a = acc_reg;
                mm_req.b = sq_reg;
            end
            ST_SQUARE:
            begin
                mm_req.a = sq_reg;
                mm_req.b = sq_reg;
            end
            default:
            begin
                mm_req.a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        if (mm_req.start)
            issued_next = 1'b1;
        if (mm_done)
            issued_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (in_xfer) state_next = ST_RED_HI;
            ST_RED_HI:
                if (mm_done) state_next = ST_RED_LO;
            ST_RED_LO:
                if (mm_done) state_next = ST_SIGN;
            ST_SIGN:
            begin
                priority if (exp_reg == '0)
                    state_next = ST_FIN;
                else if (exp_reg[0])
                    state_next = ST_MULT;
                else
                    state_next = ST_SQUARE;
            end
            ST_MULT:
                if (mm_done)
                begin
                    // skip the square after the top bit
                    if (exp_shift == '0)
                        state_next = ST_FIN;
                    else
                        state_next = ST_SQUARE;
                end
            ST_SQUARE:
                if (mm_done)
                begin
                    priority if (exp_shift == '0)
                        state_next = ST_FIN;
                    else if (exp_shift[0])
                        state_next = ST_MULT;
                    else
                        state_next = ST_SQUARE;
                end
            ST_FIN:
                if (out_load) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mag_reg <= mag;
            neg_reg <= base_bits[63];
            exp_reg <= req.exponent;
        end
        if (mm_done && (state_reg == ST_RED_HI || state_reg == ST_RED_LO))
            r_reg <= mm_result;
        if (state_reg == ST_SIGN)
        begin
            sq_reg  <= sign_res;
            acc_reg <= 30'd1;
        end
        if (mm_done && state_reg == ST_MULT)
            acc_reg <= mm_result;
        if (mm_done && state_reg == ST_SQUARE)
        begin
            sq_reg  <= mm_result;
            exp_reg <= exp_shift;
        end
        if (out_load)
            power_reg <= acc_reg;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.power = power_reg;

endmodule

@@ hw/rtl/mexp_modmul.sv @@
// ----------------------------------------------------------------------------
// mexp_modmul: shared modular multiplier
// Computes (a * b + c) mod p with Barrett reduction. One 31x31 multiplier is
// reused for the product, the quotient estimate and the quotient times p.
// ----------------------------------------------------------------------------
module mexp_modmul
    import mexp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  mexp_mm_req_t req,
    output logic         done,
    output mexp_res_t    result
);

    typedef enum logic [4:0] {
        MM_IDLE = 5'b00001,
        MM_MUL  = 5'b00010,
        MM_EST  = 5'b00100,
        MM_QP   = 5'b01000,
        MM_FIX  = 5'b10000
    } mm_phase_t;

    mm_phase_t   phase_reg, phase_next;
    mexp_res_t   a_reg, b_reg, c_reg;
    logic [59:0] t_reg;
    logic [30:0] q3_reg;
    logic [31:0] qp_reg;

    logic [30:0] mul_x, mul_y;
    logic [61:0] prod;
    logic [31:0] diff;
    logic [32:0] sub1, sub2;

    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        unique case (phase_reg)
            MM_MUL:
            begin
                mul_x = {1'b0, a_reg};
                mul_y = {1'b0, b_reg};
            end
            MM_EST:
            begin
                mul_x = t_reg[59:29];
                mul_y = BarrettMu;
            end
            MM_QP:
            begin
                mul_x = q3_reg;
                mul_y = {1'b0, Modulus};
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign prod = {31'd0, mul_x} * {31'd0, mul_y};

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            MM_IDLE: if (req.start) phase_next = MM_MUL;
            MM_MUL:  phase_next = MM_EST;
            MM_EST:  phase_next = MM_QP;
            MM_QP:   phase_next = MM_FIX;
            MM_FIX:  phase_next = MM_IDLE;
            default: phase_next = MM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= MM_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == MM_IDLE && req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
            c_reg <= req.c;
        end
        if (phase_reg == MM_MUL)
            t_reg <= prod[59:0] + {30'd0, c_reg};
        if (phase_reg == MM_EST)
            q3_reg <= prod[61:31];
        if (phase_reg == MM_QP)
            qp_reg <= prod[31:0];
    end

    // remainder estimate lies below 3p; drop up to two multiples of p
    assign diff = t_reg[31:0] - qp_reg;
    assign sub1 = {1'b0, diff} - {3'd0, Modulus};
    assign sub2 = {1'b0, diff} - {1'b0, ModTwice};

    always_comb
    begin
        priority if (!sub2[32])
            result = sub2[ResW-1:0];
        else if (!sub1[32])
            result = sub1[ResW-1:0];
        else
            result = diff[ResW-1:0];
    end

    assign done = (phase_reg == MM_FIX);

endmodule
